// ===== hdl/spf_pkg.sv =====
`default_nettype none

package spf_pkg;

    localparam int CHAR_W   = 8;
    localparam int PERIOD_W = 7;

    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [PERIOD_W-1:0] period_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/spf_if.sv =====
`default_nettype none

interface spf_char_if;
    logic            valid;
    logic            ready;
    spf_pkg::char_t  char_byte;
    logic            is_last;

    modport source (output valid, output char_byte, output is_last, input ready);
    modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface spf_period_if;
    logic             valid;
    logic             ready;
    spf_pkg::period_t period;
    logic             last_period;
    logic             overflow;

    modport source (output valid, output period, output last_period, output overflow,
                    input ready);
    modport sink   (input valid, input period, input last_period, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/spf_ram.sv =====
`default_nettype none

module spf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/string_period_finder_unit.sv =====
`default_nettype none

// String period finder. Bytes arrive one transfer per cycle on chars and are
// written into two identical character memories; the transfer with is_last set
// closes the string and starts the search, and chars stays not ready until the
// search ends. For each candidate period p = 1..n the sequencer reads the pair
// (i, i - p) for i = p..n-1, reading both memories in the read state and
// comparing the pair in the compare state, and stops a candidate at its first
// mismatch. Each period found is emitted once the sequencer sees the end of the
// walk: the emit state loads the output register, waiting while an earlier
// result is still held there and not yet taken.
// Every period is sent on periods in rising order; the last one equals n and has
// last_period set. Bytes beyond MAX_LEN are dropped and set overflow on all
// results of that string. A result may wait in the output register while the
// next string is loading.
module string_period_finder_unit #(
    parameter int MAX_LEN = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    spf_char_if.sink      chars,
    spf_period_if.source  periods
);

    import spf_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [CW-1:0]  p_reg, p_next;
    logic [CW-1:0]  i_reg, i_next;

    logic           out_valid_reg, out_valid_next;
    period_t        out_period_reg, out_period_next;
    logic           out_last_reg, out_last_next;
    logic           out_ovf_reg, out_ovf_next;

    logic           in_fire;
    logic           out_fire;
    logic           wr_en;
    logic           rd_en;
    logic [CW-1:0]  diff;
    char_t          rd_a;
    char_t          rd_b;

    assign chars.ready = (state_reg == ST_IDLE);
    assign in_fire     = chars.valid && chars.ready;
    assign out_fire    = periods.valid && periods.ready;
    assign wr_en       = in_fire && (count_reg < CW'(MAX_LEN));
    assign diff        = i_reg - p_reg;

    assign periods.valid       = out_valid_reg;
    assign periods.period      = out_period_reg;
    assign periods.last_period = out_last_reg;
    assign periods.overflow    = out_ovf_reg;

    spf_ram #(
        .WIDTH  (CHAR_W),
        .DEPTH  (MAX_LEN),
        .ADDR_W (AW)
    ) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (chars.char_byte),
        .re    (rd_en),
        .raddr (i_reg[AW-1:0]),
        .rdata (rd_a)
    );

    spf_ram #(
        .WIDTH  (CHAR_W),
        .DEPTH  (MAX_LEN),
        .ADDR_W (AW)
    ) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (chars.char_byte),
        .re    (rd_en),
        .raddr (diff[AW-1:0]),
        .rdata (rd_b)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        p_next          = p_reg;
        i_next          = i_reg;
        out_valid_next  = out_fire ? 1'b0 : out_valid_reg;
        out_period_next = out_period_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        rd_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (chars.is_last)
                    begin
                        p_next     = CW'(1);
                        i_next     = CW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (rd_a != rd_b)
                begin
                    p_next = p_reg + 1'b1;
                    i_next = p_reg + 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
                state_next = ST_READ;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || periods.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_period_next = PERIOD_W'(p_reg);
                    out_last_next   = (p_reg == count_reg);
                    out_ovf_next    = ovf_reg;
                    if (p_reg == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        i_next     = p_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        i_reg          <= i_next;
        out_period_reg <= out_period_next;
        out_last_reg   <= out_last_next;
        out_ovf_reg    <= out_ovf_next;
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spf_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int ITEM_TARGET  = 210;
    localparam int QUIET_AFTER  = 175;
    localparam int LONG_HOLD    = 600;
    localparam int TAIL_CYCLES  = 64;

    typedef struct packed {
        period_t period;
        logic    last_period;
        logic    overflow;
    } period_result_t;

    class period_scoreboard;
        char_t          store [STORE_DEPTH];
        int unsigned    count;
        bit             dropped;
        period_result_t expected [$];
        int             errors;
        int             chars_seen;
        int             strings_done;
        int             overflow_strings;
        int             periods_checked;

        function void note_char(char_t c, logic last);
            int unsigned    p;
            int unsigned    i;
            bit             match;
            period_result_t r;
            chars_seen++;
            if (count < STORE_DEPTH)
            begin
                store[count] = c;
                count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (last)
            begin
                for (p = 1; p <= count; p++)
                begin
                    match = 1'b1;
                    for (i = p; i < count; i++)
                    begin
                        if (store[i] != store[i-p])
                            match = 1'b0;
                    end
                    if (match)
                    begin
                        r.period      = period_t'(p);
                        r.last_period = (p == count);
                        r.overflow    = dropped;
                        expected      = {expected, r};
                    end
                end
                strings_done++;
                if (dropped)
                    overflow_strings++;
                count   = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_period(period_t p, logic lp, logic ov);
            period_result_t e;
            if (expected.size() == 0)
            begin
                $display("%0t ns: unexpected result period=%0d last=%0b overflow=%0b",
                         $time, p, lp, ov);
                errors++;
                return;
            end
            e = expected.pop_front();
            periods_checked++;
            if (p !== e.period)
            begin
                $display("%0t ns: period expected %0d, got %0d", $time, e.period, p);
                errors++;
            end
            if (lp !== e.last_period)
            begin
                $display("%0t ns: last_period expected %0b, got %0b (period %0d)",
                         $time, e.last_period, lp, e.period);
                errors++;
            end
            if (ov !== e.overflow)
            begin
                $display("%0t ns: overflow expected %0b, got %0b (period %0d)",
                         $time, e.overflow, ov, e.period);
                errors++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    spf_char_if   char_bus ();
    spf_period_if period_bus ();

    string_period_finder_unit #(
        .MAX_LEN (STORE_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (char_bus),
        .periods (period_bus)
    );

    always #2 clk = ~clk;

    period_scoreboard sb;
    char_t            str_buf [$];
    int               items_sent;
    bit               quiet;
    bit               idle_on;
    bit               hold_request;

    always @(posedge clk)
    begin
        if (char_bus.valid && char_bus.ready)
            sb.note_char(char_bus.char_byte, char_bus.is_last);
        if (period_bus.valid && period_bus.ready)
            sb.check_period(period_bus.period, period_bus.last_period, period_bus.overflow);
    end

    task automatic send_char(input char_t c, input logic last);
        int gap;
        @(negedge clk);
        if (!quiet && idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_byte <= c;
        char_bus.is_last   <= last;
        do @(posedge clk); while (!char_bus.ready);
        items_sent++;
        quiet = (items_sent >= QUIET_AFTER);
    endtask

    task automatic send_string();
        int i;
        for (i = 0; i < str_buf.size(); i++)
            send_char(str_buf[i], i == str_buf.size() - 1);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall bursts, one long hold on request
    initial
    begin : sink_ctrl
        int stall;
        stall = 0;
        period_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                period_bus.ready <= 1'b0;
                stall--;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                period_bus.ready <= 1'b0;
                stall = $urandom_range(0, 6);
            end
            else
            begin
                period_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int    str_idx;
        int    len;
        int    bp;
        int    mode;
        int    i;
        char_t a;
        char_t b;
        char_t pat [$];

        sb = new;
        items_sent   = 0;
        quiet        = 1'b0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        rst_n              = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_byte = '0;
        char_bus.is_last   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: single bytes at both extremes, runs, repeats, no-period strings
        str_buf = '{8'h00};                          send_string();
        str_buf = '{8'hFF};                          send_string();
        str_buf = '{8'h61, 8'h61, 8'h61, 8'h61};     send_string();
        str_buf = '{8'h61, 8'h62, 8'h61, 8'h62};     send_string();
        str_buf = '{8'h61, 8'h62, 8'h63, 8'h61, 8'h62}; send_string();
        str_buf = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00}; send_string();
        str_buf = '{8'hFF, 8'hFF, 8'h00};            send_string();

        wait_drain();
        hold_request = 1'b1;

        str_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 2) != 0);
            if (str_idx == 1)
                len = STORE_DEPTH;
            else if (str_idx == 4)
                len = STORE_DEPTH + $urandom_range(1, 6);
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);

            // 0: random bytes, 1: periodic over two letters,
            // 2: periodic over full bytes, 3: periodic with one corrupted byte
            mode = $urandom_range(0, 3);
            bp = (mode == 0) ? len : $urandom_range(1, (len > 16) ? 16 : len);
            a = char_t'($urandom_range(0, 255));
            b = char_t'($urandom_range(0, 255));
            pat.delete();
            for (i = 0; i < bp; i++)
            begin
                if (mode == 1)
                    pat = {pat, ($urandom_range(0, 1) != 0) ? a : b};
                else
                    pat = {pat, char_t'($urandom_range(0, 255))};
            end
            str_buf.delete();
            for (i = 0; i < len; i++)
                str_buf = {str_buf, pat[i % bp]};
            if (mode == 3)
                str_buf[$urandom_range(0, len - 1)] = char_t'($urandom_range(0, 255));

            send_string();
            if (str_idx == 6)
                wait_drain();
            str_idx++;
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d strings (%0d with dropped bytes), %0d chars, %0d periods checked",
                 sb.strings_done, sb.overflow_strings, sb.chars_seen, sb.periods_checked);
        if (sb.errors == 0)
            $display("[string_period_finder_unit] OK");
        else
            $display("[string_period_finder_unit] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("[string_period_finder_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/spf_pkg.sv
hdl/spf_if.sv
hdl/spf_ram.sv
hdl/string_period_finder_unit.sv
sim/testbench.sv
